// ===== hdl/gated_velocity_yaw_filter_macros.svh =====
// ----------------------------------------------------------------------------
// Gated velocity / yaw-rate filter assertion macros
// Clocked assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef GATED_VELOCITY_YAW_FILTER_MACROS_SVH
`define GATED_VELOCITY_YAW_FILTER_MACROS_SVH

// checked only out of reset
`define GVYF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define GVYF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/gvyf_pkg.sv =====
// ----------------------------------------------------------------------------
// gvyf_pkg
// Configuration register map of the gated velocity / yaw-rate filter.
// ----------------------------------------------------------------------------
package gvyf_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROC_VEL_VAR  = 3'd0,
        CFG_PROC_YAW_VAR  = 3'd1,
        CFG_GATE_DIST     = 3'd2,
        CFG_VEL_VAR_FLOOR = 3'd3,
        CFG_YAW_VAR_FLOOR = 3'd4,
        CFG_REJ_TIMEOUT   = 3'd5
    } cfg_idx_t;

    localparam logic [15:0] VAR_FLOOR_RESET = 16'd655;

endpackage

// ===== hdl/gvyf_meas_if.sv =====
// ----------------------------------------------------------------------------
// gvyf_meas_if
// Measurement channel: valid/ready with one measurement per beat.
// ----------------------------------------------------------------------------
interface gvyf_meas_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] meas_velocity;
    logic signed [DATA_WIDTH-1:0] meas_yaw_rate;
    logic        [DATA_WIDTH-1:0] meas_velocity_var;
    logic        [DATA_WIDTH-1:0] meas_yaw_rate_var;
    logic        [DATA_WIDTH-1:0] time_step;

    modport source (
        output valid, meas_velocity, meas_yaw_rate, meas_velocity_var,
               meas_yaw_rate_var, time_step,
        input  ready
    );

    modport sink (
        input  valid, meas_velocity, meas_yaw_rate, meas_velocity_var,
               meas_yaw_rate_var, time_step,
        output ready
    );
endinterface

// ===== hdl/gvyf_result_if.sv =====
// ----------------------------------------------------------------------------
// gvyf_result_if
// Result channel: valid/ready with one filtered estimate per beat.
// ----------------------------------------------------------------------------
interface gvyf_result_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic                         accepted;
    logic signed [DATA_WIDTH-1:0] velocity_estimate;
    logic signed [DATA_WIDTH-1:0] yaw_rate_estimate;

    modport source (
        output valid, accepted, velocity_estimate, yaw_rate_estimate,
        input  ready
    );

    modport sink (
        input  valid, accepted, velocity_estimate, yaw_rate_estimate,
        output ready
    );
endinterface

// ===== hdl/gated_velocity_yaw_filter.sv =====
// ----------------------------------------------------------------------------
// gated_velocity_yaw_filter
// Two scalar Kalman filters (velocity, yaw rate) behind a joint distance gate.
// ----------------------------------------------------------------------------
// Usage:
//   meas   : sink, one measurement beat (values, variances, time step).
//   result : source, one beat per measurement: accepted flag and estimates.
//   cfg_*  : register write port, taken at any edge with cfg_write_en high;
//            write only while no measurement is in flight.
// Sequence per beat:
//   first beat after reset : loads the estimates and variances directly.
//   rejected beat          : prediction and the two gate divisions only.
//   accepted beat          : also runs the four update divisions.
//   All work runs through one multiplier and one bit-serial restoring
//   divider; meas.ready is high only while the sequencer is idle.
// Reset clears the estimates, variances, reject timer and the started flag,
// and loads the register defaults. A stalled result beat is held in its
// output register; the next measurement may be taken meanwhile, and its
// result waits until the held beat is taken.
// ----------------------------------------------------------------------------
module gated_velocity_yaw_filter
    import gvyf_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    gvyf_meas_if.sink             meas,
    gvyf_result_if.source         result,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_WIDTH-1:0] cfg_data
);

    localparam int W     = DATA_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int N     = 2 * W + 2;
    localparam int CMP_W = N + 1 + F;
    localparam int CNT_W = $clog2(N + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_FIRST, S_PROC_V, S_PROC_W, S_SQ_V, S_DIV_TV, S_SQ_W, S_DIV_TW,
        S_GATE_SQ, S_GATE, S_MUL_DV, S_DIV_DV, S_MUL_VV, S_DIV_VV,
        S_MUL_DW, S_DIV_DW, S_MUL_VW, S_DIV_VW, S_OUT
    } state_t;

    state_t state_reg;

    logic [W-1:0] proc_v_reg, proc_w_reg, gate_reg, floor_v_reg, floor_w_reg;
    logic [W-1:0] timeout_reg;

    logic         started_reg;
    logic [W-1:0] est_v_reg, est_w_reg, var_v_reg, var_w_reg, rej_reg;

    logic [W-1:0] mv_reg, mw_reg, vv_reg, wv_reg, dt_reg;
    logic [W-1:0] pv_reg, pw_reg;
    logic [N:0]   d2_reg;
    logic         inf_reg;
    logic         acc_reg;

    logic [N-1:0] prod_reg;
    logic [N-1:0] quo_reg;
    logic [W:0]   rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic         run_reg;

    logic         out_valid_reg;
    logic         out_acc_reg;
    logic [W-1:0] out_v_reg, out_w_reg;

    logic signed [W:0] rv, rw;
    logic [W:0]   rv_mag, rw_mag;
    logic [W:0]   s_v, s_w;
    logic [W:0]   mul_a, mul_b;
    logic [N-1:0] mul_p;
    logic [W:0]   div_d;
    logic [W+1:0] rem_sh;
    logic         div_ge;
    logic [W-1:0] pred_from_prod_v, pred_from_prod_w;
    logic         gate_over, forced;
    logic [W:0]   est_v_upd, est_w_upd;

    function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[W] ? {W{1'b1}} : s[W-1:0];
    endfunction

    function automatic logic [W-1:0] frac_sat(input logic [N-1:0] p);
        return (|p[N-1:W+F]) ? {W{1'b1}} : p[W+F-1:F];
    endfunction

    function automatic logic [W-1:0] max_u(input logic [W-1:0] a, input logic [W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    assign rv     = $signed({mv_reg[W-1], mv_reg}) - $signed({est_v_reg[W-1], est_v_reg});
    assign rw     = $signed({mw_reg[W-1], mw_reg}) - $signed({est_w_reg[W-1], est_w_reg});
    assign rv_mag = rv[W] ? (W+1)'(-rv) : rv;
    assign rw_mag = rw[W] ? (W+1)'(-rw) : rw;
    assign s_v    = {1'b0, pv_reg} + {1'b0, vv_reg};
    assign s_w    = {1'b0, pw_reg} + {1'b0, wv_reg};

    assign pred_from_prod_v = sat_add(var_v_reg, frac_sat(prod_reg));
    assign pred_from_prod_w = sat_add(var_w_reg, frac_sat(prod_reg));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_PROC_V:
            begin
                mul_a = {1'b0, proc_v_reg};
                mul_b = {1'b0, dt_reg};
            end
            S_PROC_W:
            begin
                mul_a = {1'b0, proc_w_reg};
                mul_b = {1'b0, dt_reg};
            end
            S_SQ_V:
            begin
                mul_a = rv_mag;
                mul_b = rv_mag;
            end
            S_SQ_W:
            begin
                mul_a = rw_mag;
                mul_b = rw_mag;
            end
            S_GATE_SQ:
            begin
                mul_a = {1'b0, gate_reg};
                mul_b = {1'b0, gate_reg};
            end
            S_MUL_DV:
            begin
                mul_a = rv_mag;
                mul_b = {1'b0, pv_reg};
            end
            S_MUL_VV:
            begin
                mul_a = {1'b0, pv_reg};
                mul_b = {1'b0, vv_reg};
            end
            S_MUL_DW:
            begin
                mul_a = rw_mag;
                mul_b = {1'b0, pw_reg};
            end
            S_MUL_VW:
            begin
                mul_a = {1'b0, pw_reg};
                mul_b = {1'b0, wv_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        case (state_reg)
            S_DIV_TW, S_DIV_DW, S_DIV_VW: div_d = s_w;
            default:                      div_d = s_v;
        endcase
    end

    assign rem_sh = {rem_reg, quo_reg[N-1]};
    assign div_ge = rem_sh >= {1'b0, div_d};

    assign gate_over = inf_reg || ({d2_reg, {F{1'b0}}} > CMP_W'(prod_reg));
    assign forced    = rej_reg >= timeout_reg;

    assign est_v_upd = rv[W] ? ({est_v_reg[W-1], est_v_reg} - quo_reg[W:0])
                             : ({est_v_reg[W-1], est_v_reg} + quo_reg[W:0]);
    assign est_w_upd = rw[W] ? ({est_w_reg[W-1], est_w_reg} - quo_reg[W:0])
                             : ({est_w_reg[W-1], est_w_reg} + quo_reg[W:0]);

    assign meas.ready               = (state_reg == S_IDLE);
    assign result.valid             = out_valid_reg;
    assign result.accepted          = out_acc_reg;
    assign result.velocity_estimate = out_v_reg;
    assign result.yaw_rate_estimate = out_w_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proc_v_reg  <= W'(1) << F;
            proc_w_reg  <= W'(1) << F;
            gate_reg    <= W'(3) << F;
            floor_v_reg <= W'(VAR_FLOOR_RESET);
            floor_w_reg <= W'(VAR_FLOOR_RESET);
            timeout_reg <= W'(1) << F;
        end
        else if (cfg_write_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PROC_VEL_VAR:  proc_v_reg  <= cfg_data;
                CFG_PROC_YAW_VAR:  proc_w_reg  <= cfg_data;
                CFG_GATE_DIST:     gate_reg    <= cfg_data;
                CFG_VEL_VAR_FLOOR: floor_v_reg <= cfg_data;
                CFG_YAW_VAR_FLOOR: floor_w_reg <= cfg_data;
                CFG_REJ_TIMEOUT:   timeout_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // datapath operands and products, no reset needed
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (meas.valid && state_reg == S_IDLE)
        begin
            mv_reg <= meas.meas_velocity;
            mw_reg <= meas.meas_yaw_rate;
            vv_reg <= meas.meas_velocity_var;
            wv_reg <= meas.meas_yaw_rate_var;
            dt_reg <= meas.time_step;
        end
    end

    // sequencer, filter state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            est_v_reg     <= '0;
            est_w_reg     <= '0;
            var_v_reg     <= '0;
            var_w_reg     <= '0;
            rej_reg       <= '0;
            pv_reg        <= '0;
            pw_reg        <= '0;
            d2_reg        <= '0;
            inf_reg       <= 1'b0;
            acc_reg       <= 1'b0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_acc_reg   <= 1'b0;
            out_v_reg     <= '0;
            out_w_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && result.ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (meas.valid)
                    begin
                        state_reg <= started_reg ? S_PROC_V : S_FIRST;
                    end
                end
                S_FIRST:
                begin
                    est_v_reg   <= mv_reg;
                    est_w_reg   <= mw_reg;
                    var_v_reg   <= max_u(vv_reg, floor_v_reg);
                    var_w_reg   <= max_u(wv_reg, floor_w_reg);
                    started_reg <= 1'b1;
                    acc_reg     <= 1'b1;
                    state_reg   <= S_OUT;
                end
                S_PROC_V:
                begin
                    d2_reg    <= '0;
                    inf_reg   <= 1'b0;
                    state_reg <= S_PROC_W;
                end
                S_PROC_W:
                begin
                    pv_reg    <= pred_from_prod_v;
                    state_reg <= S_SQ_V;
                end
                S_SQ_V:
                begin
                    pw_reg    <= pred_from_prod_w;
                    state_reg <= S_DIV_TV;
                end
                S_SQ_W:      state_reg <= S_DIV_TW;
                S_GATE_SQ:   state_reg <= S_GATE;
                S_MUL_DV:    state_reg <= S_DIV_DV;
                S_MUL_VV:    state_reg <= S_DIV_VV;
                S_MUL_DW:    state_reg <= S_DIV_DW;
                S_MUL_VW:    state_reg <= S_DIV_VW;
                S_GATE:
                begin
                    if (!forced && gate_over)
                    begin
                        var_v_reg <= max_u(pv_reg, floor_v_reg);
                        var_w_reg <= max_u(pw_reg, floor_w_reg);
                        rej_reg   <= sat_add(rej_reg, dt_reg);
                        acc_reg   <= 1'b0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        rej_reg   <= '0;
                        acc_reg   <= 1'b1;
                        state_reg <= S_MUL_DV;
                    end
                end
                S_DIV_TV, S_DIV_TW, S_DIV_DV, S_DIV_VV, S_DIV_DW, S_DIV_VW:
                begin
                    if (!run_reg)
                    begin
                        quo_reg <= prod_reg;
                        rem_reg <= '0;
                        cnt_reg <= CNT_W'(N);
                        run_reg <= 1'b1;
                    end
                    else if (cnt_reg != '0)
                    begin
                        rem_reg <= div_ge ? (W+1)'(rem_sh - {1'b0, div_d}) : rem_sh[W:0];
                        quo_reg <= {quo_reg[N-2:0], div_ge};
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                    else
                    begin
                        run_reg <= 1'b0;
                        case (state_reg)
                            S_DIV_TV:
                            begin
                                if (s_v == '0)
                                begin
                                    inf_reg <= inf_reg | (rv != '0);
                                end
                                else
                                begin
                                    d2_reg <= {1'b0, quo_reg};
                                end
                                state_reg <= S_SQ_W;
                            end
                            S_DIV_TW:
                            begin
                                if (s_w == '0)
                                begin
                                    inf_reg <= inf_reg | (rw != '0);
                                end
                                else
                                begin
                                    d2_reg <= d2_reg + {1'b0, quo_reg};
                                end
                                state_reg <= S_GATE_SQ;
                            end
                            S_DIV_DV:
                            begin
                                if (s_v != '0)
                                begin
                                    est_v_reg <= est_v_upd[W-1:0];
                                end
                                state_reg <= S_MUL_VV;
                            end
                            S_DIV_VV:
                            begin
                                var_v_reg <= (s_v == '0) ? floor_v_reg
                                           : max_u(quo_reg[W-1:0], floor_v_reg);
                                state_reg <= S_MUL_DW;
                            end
                            S_DIV_DW:
                            begin
                                if (s_w != '0)
                                begin
                                    est_w_reg <= est_w_upd[W-1:0];
                                end
                                state_reg <= S_MUL_VW;
                            end
                            default:
                            begin
                                var_w_reg <= (s_w == '0) ? floor_w_reg
                                           : max_u(quo_reg[W-1:0], floor_w_reg);
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_acc_reg   <= acc_reg;
                        out_v_reg     <= est_v_reg;
                        out_w_reg     <= est_w_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/gvyf_checker.sv =====
// ----------------------------------------------------------------------------
// gvyf_checker
// Port-level checks of the gated velocity / yaw-rate filter, bound to it.
// ----------------------------------------------------------------------------
`include "gated_velocity_yaw_filter_macros.svh"

module gvyf_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  meas_valid,
    input logic                  meas_ready,
    input logic                  res_valid,
    input logic                  res_ready,
    input logic                  res_accepted,
    input logic [DATA_WIDTH-1:0] res_vel,
    input logic [DATA_WIDTH-1:0] res_yaw
);

    logic                      meas_take;
    logic                      res_stall;
    logic [2*DATA_WIDTH:0]     res_beat;

    assign meas_take = meas_valid && meas_ready;
    assign res_stall = res_valid && !res_ready;
    assign res_beat  = {res_accepted, res_vel, res_yaw};

    `GVYF_ASSERT_ALWAYS(a_no_beat_in_reset, !rst_n |-> !res_valid, "result beat during reset")
    `GVYF_ASSERT(a_busy_after_take, meas_take |=> !meas_ready, "ready while busy")
    `GVYF_ASSERT(a_no_instant_result, meas_take |=> !$rose(res_valid), "result too early")
    `GVYF_ASSERT(a_res_hold, res_stall |=> res_valid, "result beat dropped")
    `GVYF_ASSERT(a_res_stable, res_stall |=> $stable(res_beat), "stalled result changed")

endmodule

bind gated_velocity_yaw_filter gvyf_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_gvyf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .meas_valid   (meas.valid),
    .meas_ready   (meas.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_accepted (result.accepted),
    .res_vel      (result.velocity_estimate),
    .res_yaw      (result.yaw_rate_estimate)
);
